// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the principal stress core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PSD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`else

`define PSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PSD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: src/psd_pkg.sv
// Types and constants shared by the principal stress core.
`timescale 1ns / 1ps

package psd_pkg;

    // Radicand (2R)^2 in LSB^2 stays below 2^66.
    localparam int RAD_W      = 66;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    // The partial remainder never exceeds twice the partial root.
    localparam int REM_W      = ROOT_W + 1;
    // Four front-end stages, one stage per root bit and the output register.
    localparam int PREP_STAGES = 4;
    localparam int LATENCY     = PREP_STAGES + SQRT_STEPS + 1;

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    typedef struct packed {
        logic signed [31:0] sigma_xx;
        logic signed [31:0] sigma_yy;
        logic signed [31:0] tau_xy;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] sigma_major;
        logic signed [31:0] sigma_minor;
        logic               last_out;
    } out_t;

    // Data that rides alongside the square root pipeline.
    typedef struct packed {
        logic signed [32:0] sum;
        logic               last;
    } side_t;

endpackage

// File: src/psd_prep.sv
// Front end: sum and difference, magnitudes, squares and the radicand.
`timescale 1ns / 1ps

module psd_prep
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  psd_pkg::in_t               in_data,
    output logic                       rad_valid,
    output logic [psd_pkg::RAD_W-1:0]  rad,
    output psd_pkg::side_t             rad_side
);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    psd_pkg::side_t       s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [32:0]   diff_reg;
    logic signed [31:0]   tau_reg;
    logic [31:0]          da_reg, ta_reg;
    logic [63:0]          d2_reg;
    logic [62:0]          t2_reg;
    logic [psd_pkg::RAD_W-1:0] rad_reg;

    logic signed [32:0]   diff_next;
    psd_pkg::side_t       s1_next;
    logic [32:0]          da_wide;
    logic [31:0]          da_next, ta_next;
    logic [63:0]          d2_next, t2_full;
    logic [psd_pkg::RAD_W-1:0] rad_next;

    always_comb
    begin
        s1_next.sum  = 33'(in_data.sigma_xx) + 33'(in_data.sigma_yy);
        s1_next.last = in_data.last_in;
        diff_next    = 33'(in_data.sigma_xx) - 33'(in_data.sigma_yy);
    end

    always_comb
    begin
        da_wide = diff_reg[32] ? (~diff_reg + 33'sd1) : diff_reg;
        da_next = da_wide[31:0];
        // The most negative shear still fits as an unsigned magnitude.
        ta_next = tau_reg[31] ? (~tau_reg + 32'sd1) : tau_reg;
    end

    always_comb
    begin
        d2_next = 64'(da_reg) * 64'(da_reg);
        t2_full = 64'(ta_reg) * 64'(ta_reg);
    end

    always_comb
    begin
        rad_next = {2'b00, d2_reg} + {1'b0, t2_reg, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        diff_reg <= diff_next;
        tau_reg  <= in_data.tau_xy;
        s2_reg   <= s1_reg;
        da_reg   <= da_next;
        ta_reg   <= ta_next;
        s3_reg   <= s2_reg;
        d2_reg   <= d2_next;
        t2_reg   <= t2_full[62:0];
        s4_reg   <= s3_reg;
        rad_reg  <= rad_next;
    end

    assign rad_valid = v4_reg;
    assign rad       = rad_reg;
    assign rad_side  = s4_reg;

endmodule

// File: src/psd_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps

module psd_isqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [psd_pkg::RAD_W-1:0]   rad,
    input  psd_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [psd_pkg::ROOT_W-1:0]  root,
    output psd_pkg::side_t              out_side
);

    logic                        vld_reg  [psd_pkg::SQRT_STEPS];
    logic [psd_pkg::RAD_W-1:0]   rad_reg  [psd_pkg::SQRT_STEPS];
    logic [psd_pkg::ROOT_W-1:0]  root_reg [psd_pkg::SQRT_STEPS];
    logic [psd_pkg::REM_W-1:0]   rem_reg  [psd_pkg::SQRT_STEPS];
    psd_pkg::side_t              side_reg [psd_pkg::SQRT_STEPS];

    for (genvar k = 0; k < psd_pkg::SQRT_STEPS; k++)
    begin : g_step
        logic                        vld_prev;
        logic [psd_pkg::RAD_W-1:0]   rad_prev;
        logic [psd_pkg::ROOT_W-1:0]  root_prev;
        logic [psd_pkg::REM_W-1:0]   rem_prev;
        psd_pkg::side_t              side_prev;
        logic [psd_pkg::REM_W+1:0]   cand;
        logic [psd_pkg::REM_W+1:0]   trial;
        logic [psd_pkg::REM_W+1:0]   left;
        logic                        take;
        logic [psd_pkg::REM_W-1:0]   rem_next;
        logic [psd_pkg::ROOT_W-1:0]  root_next;
        logic [psd_pkg::RAD_W-1:0]   rad_next;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rad_prev  = rad;
            assign root_prev = '0;
            assign rem_prev  = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            cand      = {rem_prev, rad_prev[psd_pkg::RAD_W-1 -: 2]};
            trial     = {1'b0, root_prev, 2'b01};
            take      = (cand >= trial);
            left      = cand - trial;
            // Whatever remains is below 2^REM_W, so the top bits drop safely.
            rem_next  = take ? left[psd_pkg::REM_W-1:0] : cand[psd_pkg::REM_W-1:0];
            root_next = {root_prev[psd_pkg::ROOT_W-2:0], take};
            rad_next  = {rad_prev[psd_pkg::RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_next;
            root_reg[k] <= root_next;
            rem_reg[k]  <= rem_next;
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = vld_reg[psd_pkg::SQRT_STEPS-1];
    assign root      = root_reg[psd_pkg::SQRT_STEPS-1];
    assign out_side  = side_reg[psd_pkg::SQRT_STEPS-1];

endmodule

// File: src/psd_round.sv
// Output stage: average plus and minus the radius, saturated and registered.
`timescale 1ns / 1ps

module psd_round
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [psd_pkg::ROOT_W-1:0]  root,
    input  psd_pkg::side_t              in_side,
    output logic                        done,
    output psd_pkg::out_t               result
);

    logic                 done_reg;
    psd_pkg::out_t        result_reg;
    psd_pkg::out_t        result_next;
    logic signed [31:0]   half_sum;
    logic [31:0]          radius;
    logic signed [33:0]   major_wide, minor_wide;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > psd_pkg::SAT_MAX)
            r = psd_pkg::SAT_MAX[31:0];
        else if (v < psd_pkg::SAT_MIN)
            r = psd_pkg::SAT_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb
    begin
        // The radius is added in whole LSBs, so flooring the half sum first
        // gives the same result as flooring after the addition.
        half_sum   = in_side.sum[32:1];
        radius     = root[psd_pkg::ROOT_W-1:1];
        major_wide = 34'(half_sum) + $signed({2'b00, radius});
        minor_wide = 34'(half_sum) - $signed({2'b00, radius});
        result_next.sigma_major = sat32(major_wide);
        result_next.sigma_minor = sat32(minor_wide);
        result_next.last_out    = in_side.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: src/principal_stress_2d_core.sv
// Principal stress core: top level joining front end, square root and output.
//
// Usage: present a plane stress beat on item with start high; it is taken at
// any rising edge where start is high and busy is low. busy never rises, so a
// new beat may be offered on every cycle and the core sustains one beat per
// clock.
// Each beat yields exactly one result beat, shown on result for a single
// cycle with done high, in the same order as the inputs. The path runs
// through four front-end stages (sum and difference, magnitudes, squares,
// radicand), 33 square root stages that each settle one root bit, and the
// output register. The receiver cannot stall; a result must be taken in its
// done cycle. Reset clears every valid bit at once, so any beats in flight
// are dropped and no result appears until new beats are accepted. No state
// survives from one beat to the next.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module principal_stress_2d_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  psd_pkg::in_t   item,
    output logic           done,
    output psd_pkg::out_t  result
);

    logic                        accept;
    logic                        rad_valid;
    logic [psd_pkg::RAD_W-1:0]   rad;
    psd_pkg::side_t              rad_side;
    logic                        root_valid;
    logic [psd_pkg::ROOT_W-1:0]  root;
    psd_pkg::side_t              root_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    psd_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (item),
        .rad_valid (rad_valid),
        .rad       (rad),
        .rad_side  (rad_side)
    );

    psd_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_valid),
        .rad       (rad),
        .in_side   (rad_side),
        .out_valid (root_valid),
        .root      (root),
        .out_side  (root_side)
    );

    psd_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (root_valid),
        .root     (root),
        .in_side  (root_side),
        .done     (done),
        .result   (result)
    );

    // A result beat only ever follows an accepted beat by the full latency.
    `PSD_ASSERT_IMPLIES(a_done_latency, clk, rst_n, done, $past(accept, psd_pkg::LATENCY))
    // The batch marker leaves with the beat it entered with.
    `PSD_ASSERT_IMPLIES(a_last_follows, clk, rst_n, done, result.last_out == $past(item.last_in, psd_pkg::LATENCY))
    // The major stress can never fall below the minor one, saturated or not.
    `PSD_ASSERT_NEVER(a_major_order, clk, rst_n, done && (result.sigma_major < result.sigma_minor))

endmodule

// File: tb/principal_stress_checker.sv
// Checker for the principal stress core: predicts each result beat and compares it.
`timescale 1ns / 1ps

module principal_stress_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  psd_pkg::in_t   item,
    input  logic           done,
    input  psd_pkg::out_t  result,
    output int             mismatches,
    output int             outstanding
);

    localparam logic signed [39:0] TOP_LIMIT    = 40'sd2147483647;
    localparam logic signed [39:0] BOTTOM_LIMIT = -40'sd2147483648;

    psd_pkg::out_t predicted_pairs[$];

    function automatic logic signed [31:0] clamp32(logic signed [39:0] v);
        if (v > TOP_LIMIT)
            return TOP_LIMIT[31:0];
        if (v < BOTTOM_LIMIT)
            return BOTTOM_LIMIT[31:0];
        return v[31:0];
    endfunction

    function automatic psd_pkg::out_t principal_pair(psd_pkg::in_t x);
        logic signed [39:0] sx;
        logic signed [39:0] sy;
        logic signed [39:0] sh;
        logic signed [39:0] total;
        logic signed [39:0] delta;
        logic signed [39:0] twice_r;
        logic [67:0]        dmag;
        logic [67:0]        tmag;
        logic [67:0]        radicand;
        logic [67:0]        root;
        logic [67:0]        trial;
        psd_pkg::out_t      y;
        sx = x.sigma_xx;
        sy = x.sigma_yy;
        sh = x.tau_xy;
        total = sx + sy;
        delta = sx - sy;
        dmag = (delta < 0) ? 68'(-delta) : 68'(delta);
        tmag = (sh < 0) ? 68'(-sh) : 68'(sh);
        // Radicand is (2R)^2 in LSB squared, exact in 68 bits.
        radicand = dmag * dmag + ((tmag * tmag) << 2);
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = root | (68'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        // R is the truncated root halved, so 2R is the root with its low bit cleared.
        twice_r = root[39:0] & ~40'd1;
        y.sigma_major = clamp32((total + twice_r) >>> 1);
        y.sigma_minor = clamp32((total - twice_r) >>> 1);
        y.last_out    = x.last_in;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        psd_pkg::out_t want;
        if (!rst_n)
        begin
            predicted_pairs.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (start && !busy)
                predicted_pairs.push_back(principal_pair(item));
            if (done)
            begin
                if (predicted_pairs.size() == 0)
                begin
                    $display("%0t: expected no beat, actual major=%h minor=%h last=%b",
                             $time, result.sigma_major, result.sigma_minor,
                             result.last_out);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = predicted_pairs.pop_front();
                    if (want.sigma_major !== result.sigma_major)
                        $display("%0t: sigma_major expected %h actual %h",
                                 $time, want.sigma_major, result.sigma_major);
                    if (want.sigma_minor !== result.sigma_minor)
                        $display("%0t: sigma_minor expected %h actual %h",
                                 $time, want.sigma_minor, result.sigma_minor);
                    if (want.last_out !== result.last_out)
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last_out, result.last_out);
                    if (want !== result)
                        mismatches <= mismatches + 1;
                end
            end
            outstanding <= predicted_pairs.size();
        end
    end

endmodule

// File: tb/tb_principal_stress_2d_core.sv
// Testbench top for the principal stress core: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_principal_stress_2d_core;

    localparam logic signed [31:0] MAX_S = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_S = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam int RANDOM_BEATS = 1650;
    localparam int QUIET_TAIL   = 200;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    psd_pkg::in_t   item = '0;
    logic           done;
    psd_pkg::out_t  result;
    int             mismatches;
    int             outstanding;

    always #1 clk = ~clk;

    principal_stress_2d_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    principal_stress_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_stress(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] txy, logic last);
        item  <= '{sigma_xx: sx, sigma_yy: sy, tau_xy: txy, last_in: last};
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
            7:
            begin
                case ($urandom_range(0, 4))
                    0: return MAX_S;
                    1: return MIN_S;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h7FFF)) <<< 16;
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] txy;
        bit                 bursty;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, odd sums, equal stresses with no shear and saturating cases.
        send_stress(0, 0, 0, 1'b0);
        send_stress(MAX_S, MAX_S, MAX_S, 1'b1);
        send_stress(MIN_S, MIN_S, MIN_S, 1'b0);
        send_stress(MAX_S, MIN_S, 0, 1'b1);
        send_stress(MIN_S, MAX_S, 0, 1'b0);
        send_stress(MAX_S, MIN_S, MAX_S, 1'b0);
        send_stress(MIN_S, MAX_S, MIN_S, 1'b1);
        send_stress(MIN_S, MIN_S, 0, 1'b0);
        send_stress(MAX_S, MAX_S, 0, 1'b0);
        send_stress(1, 0, 0, 1'b0);
        send_stress(-1, 0, 0, 1'b1);
        send_stress(-1, -2, 0, 1'b0);
        send_stress(5 * ONE_Q, 5 * ONE_Q, 0, 1'b0);
        send_stress(-3, -3, 0, 1'b1);
        send_stress(0, 0, MIN_S, 1'b0);
        send_stress(0, 0, MAX_S, 1'b0);
        send_stress(0, 0, 1, 1'b0);
        send_stress(0, 0, -1, 1'b1);
        send_stress(3 * ONE_Q, -2 * ONE_Q, ONE_Q, 1'b0);
        send_stress(MAX_S, 0, MIN_S, 1'b1);
        wait_until_drained();

        bursty = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // Each run of 100 beats randomly has gaps or goes at full rate; the last QUIET_TAIL beats have no gaps.
            if (n % 100 == 0)
                bursty = $urandom_range(0, 2) != 0;
            if (n == RANDOM_BEATS / 2)
                wait_until_drained();
            sx  = pick_value();
            sy  = ($urandom_range(0, 7) == 0) ? sx : pick_value();
            txy = ($urandom_range(0, 7) == 0) ? 32'sd0 : pick_value();
            send_stress(sx, sy, txy, 1'($urandom_range(0, 1)));
            if (bursty && n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 19));
        end

        wait_until_drained();
        repeat (psd_pkg::LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
